FILE: rtl/core/text_console_cursor_control_defines.svh
// Assertion macros for the text console cursor controller.
// Used by tccc_outbuf, the RTL file that carries concurrent assertions; needs clk_i and rst_ni in scope.
`ifndef TEXT_CONSOLE_CURSOR_CONTROL_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_CONTROL_DEFINES_SVH

// Same-cycle implication.
`define TCCC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TCCC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/tccc_pkg.sv
// Types and constants of the text console cursor controller.
// No dependencies.
`default_nettype none

package tccc_pkg;

  localparam int CellWidthDefault  = 8;
  localparam int CellHeightDefault = 16;
  localparam int TabStep           = 8;

  localparam logic [7:0] CharCr    = 8'h0D;
  localparam logic [7:0] CharLf    = 8'h0A;
  localparam logic [7:0] CharBs    = 8'h08;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharSpace = 8'h20;

  localparam int CfgIdxWidth = 3;

  typedef enum logic [1:0] {
    CMD_DRAW   = 2'd0,
    CMD_SCROLL = 2'd1,
    CMD_CLEAR  = 2'd2
  } cmd_e;

  typedef enum logic [CfgIdxWidth-1:0] {
    REG_COLUMNS         = 3'd0,
    REG_TEXT_ROWS       = 3'd1,
    REG_DISPLAY_PRESENT = 3'd2,
    REG_FIRST_GLYPH     = 3'd3,
    REG_LAST_GLYPH      = 3'd4
  } reg_idx_e;

  typedef struct packed {
    logic       mode;
    logic [7:0] char_code;
    logic       enable_on;
  } item_t;

  typedef struct packed {
    logic [7:0] columns;
    logic [7:0] text_rows;
    logic       display_present;
    logic [7:0] first_glyph;
    logic [7:0] last_glyph;
  } cfg_t;

  typedef struct packed {
    logic [7:0] col;
    logic [7:0] line;
    logic       active;
  } cursor_t;

  typedef struct packed {
    cmd_e        command;
    logic [7:0]  cell_col;
    logic [7:0]  cell_row;
    logic [10:0] pixel_x;
    logic [11:0] pixel_y;
    logic [7:0]  glyph_code;
    logic        last;
  } result_t;

  typedef struct packed {
    logic       valid;
    logic [1:0] n;
    result_t    r0;
    result_t    r1;
  } push_t;

endpackage

`default_nettype wire

FILE: rtl/core/tccc_in_if.sv
// Input channel of the text console cursor controller.
// Valid/ready handshake with the item fields; no dependencies.
`default_nettype none

interface tccc_in_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] char_code;
  logic       enable_on;

  modport source (output valid, mode, char_code, enable_on, input ready);
  modport sink   (input valid, mode, char_code, enable_on, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tccc_out_if.sv
// Result channel of the text console cursor controller.
// Valid/ready handshake with the command fields; no dependencies.
`default_nettype none

interface tccc_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [7:0]  cell_col;
  logic [7:0]  cell_row;
  logic [10:0] pixel_x;
  logic [11:0] pixel_y;
  logic [7:0]  glyph_code;
  logic        last;

  modport source (output valid, command, cell_col, cell_row, pixel_x, pixel_y, glyph_code,
                  last, input ready);
  modport sink   (input valid, command, cell_col, cell_row, pixel_x, pixel_y, glyph_code,
                  last, output ready);
endinterface

`default_nettype wire

FILE: rtl/core/tccc_step.sv
// Cursor step logic: next cursor state and up to two commands for one item.
// Depends on tccc_pkg.
`default_nettype none

module tccc_step import tccc_pkg::*; #(
  parameter int CellWidth  = CellWidthDefault,
  parameter int CellHeight = CellHeightDefault
) (
  input  item_t   item_i,
  input  cfg_t    cfg_i,
  input  cursor_t cur_i,
  output cursor_t cur_o,
  output push_t   push_o
);

  logic [7:0] eff_cols;
  logic [7:0] eff_rows;
  logic [7:0] last_row;
  logic [8:0] nl_row;
  logic       nl_scroll;
  logic [7:0] nl_line;
  logic [8:0] tab_col;
  logic [8:0] inc_col;
  logic [7:0] glyph;
  logic [1:0] n;
  result_t    r0;
  result_t    r1;
  result_t    scroll_res;

  function automatic result_t mk(cmd_e c, logic [7:0] col, logic [7:0] row, logic [7:0] g);
    logic [12:0] px;
    logic [12:0] py;
    result_t     r;
    px           = 13'(col) * 13'(CellWidth);
    py           = 13'(row) * 13'(CellHeight);
    r.command    = c;
    r.cell_col   = col;
    r.cell_row   = row;
    r.pixel_x    = px[10:0];
    r.pixel_y    = py[11:0];
    r.glyph_code = g;
    r.last       = 1'b0;
    return r;
  endfunction

  assign eff_cols  = (cfg_i.columns == 8'd0) ? 8'd1 : cfg_i.columns;
  assign eff_rows  = (cfg_i.text_rows == 8'd0) ? 8'd1 : cfg_i.text_rows;
  assign last_row  = eff_rows - 8'd1;
  assign nl_row    = {1'b0, cur_i.line} + 9'd1;
  assign nl_scroll = nl_row >= {1'b0, eff_rows};
  assign nl_line   = nl_scroll ? last_row : nl_row[7:0];
  assign tab_col   = ({1'b0, cur_i.col} + 9'(TabStep)) & ~9'(TabStep - 1);
  assign inc_col   = {1'b0, cur_i.col} + 9'd1;
  assign glyph     = (item_i.char_code < cfg_i.first_glyph ||
                      item_i.char_code > cfg_i.last_glyph) ? CharSpace : item_i.char_code;
  assign scroll_res = mk(CMD_SCROLL, 8'd0, last_row, 8'd0);

  always_comb begin
    cur_o = cur_i;
    n     = 2'd0;
    r0    = mk(CMD_DRAW, 8'd0, 8'd0, 8'd0);
    r1    = scroll_res;
    if (item_i.mode) begin
      cur_o.active = item_i.enable_on & cfg_i.display_present;
      if (cur_o.active) begin
        cur_o.col  = 8'd0;
        cur_o.line = 8'd0;
        r0         = mk(CMD_CLEAR, 8'd0, 8'd0, 8'd0);
        n          = 2'd1;
      end
    end else if (cur_i.active) begin
      case (item_i.char_code)
        CharCr: begin
          cur_o.col = 8'd0;
        end
        CharLf: begin
          cur_o.col  = 8'd0;
          cur_o.line = nl_line;
          if (nl_scroll) begin
            r0 = scroll_res;
            n  = 2'd1;
          end
        end
        CharBs: begin
          if (cur_i.col != 8'd0) begin
            cur_o.col = cur_i.col - 8'd1;
            r0        = mk(CMD_DRAW, cur_i.col - 8'd1, cur_i.line, CharSpace);
            n         = 2'd1;
          end
        end
        CharTab: begin
          if (tab_col >= {1'b0, eff_cols}) begin
            cur_o.col  = 8'd0;
            cur_o.line = nl_line;
            if (nl_scroll) begin
              r0 = scroll_res;
              n  = 2'd1;
            end
          end else begin
            cur_o.col = tab_col[7:0];
          end
        end
        default: begin
          r0 = mk(CMD_DRAW, cur_i.col, cur_i.line, glyph);
          n  = 2'd1;
          if (inc_col >= {1'b0, eff_cols}) begin
            cur_o.col  = 8'd0;
            cur_o.line = nl_line;
            if (nl_scroll) begin
              n = 2'd2;
            end
          end else begin
            cur_o.col = inc_col[7:0];
          end
        end
      endcase
    end
    r0.last = (n == 2'd1);
    r1.last = 1'b1;
  end

  assign push_o.valid = 1'b1;
  assign push_o.n     = n;
  assign push_o.r0    = r0;
  assign push_o.r1    = r1;

endmodule

`default_nettype wire

FILE: rtl/core/tccc_outbuf.sv
// Two-slot result buffer: loads up to two commands at once, drives them out in order.
// Depends on tccc_pkg, tccc_out_if and the assertion macros.
`default_nettype none
`include "text_console_cursor_control_defines.svh"

module tccc_outbuf import tccc_pkg::*; (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  input  push_t       push_i,
  output logic        room_o,
  tccc_out_if.source  out_o
);

  result_t    s0_q, s0_d;
  result_t    s1_q, s1_d;
  logic [1:0] cnt_q, cnt_d;
  logic       pop;

  assign pop    = out_o.valid & out_o.ready;
  assign room_o = (cnt_q == 2'd0) || (cnt_q == 2'd1 && pop);

  always_comb begin
    s0_d  = s0_q;
    s1_d  = s1_q;
    cnt_d = cnt_q - {1'b0, pop};
    if (push_i.valid) begin
      s0_d  = push_i.r0;
      s1_d  = push_i.r1;
      cnt_d = push_i.n;
    end else if (pop) begin
      s0_d = s1_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 2'd0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_q <= s0_d;
    s1_q <= s1_d;
  end

  assign out_o.valid      = cnt_q != 2'd0;
  assign out_o.command    = s0_q.command;
  assign out_o.cell_col   = s0_q.cell_col;
  assign out_o.cell_row   = s0_q.cell_row;
  assign out_o.pixel_x    = s0_q.pixel_x;
  assign out_o.pixel_y    = s0_q.pixel_y;
  assign out_o.glyph_code = s0_q.glyph_code;
  assign out_o.last       = s0_q.last;

  `TCCC_ASSERT_IMP(a_cnt_range, 1'b1, cnt_q != 2'd3, "result count out of range")
  `TCCC_ASSERT_IMP(a_push_room, push_i.valid, room_o, "commands loaded over pending ones")
  `TCCC_ASSERT_NXT(a_push_cnt, push_i.valid, cnt_q == $past(push_i.n), "load count lost")
  `TCCC_ASSERT_NXT(a_hold, cnt_q == 2'd2 && !pop, cnt_q == 2'd2 && $stable(s0_q),
                   "stalled command changed")

endmodule

`default_nettype wire

FILE: rtl/core/text_console_cursor_control.sv
// Text console cursor controller: an accepted item is registered, then stepped into the
// two-slot result buffer when it has room; a draw followed by a scroll fills both slots
// (the buffer has one output port). Configuration is five plain write registers.
// Depends on tccc_pkg, tccc_in_if, tccc_out_if, tccc_step and tccc_outbuf.
`default_nettype none

module text_console_cursor_control import tccc_pkg::*; #(
  parameter int CellWidth  = CellWidthDefault,
  parameter int CellHeight = CellHeightDefault
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire logic [CfgIdxWidth-1:0] cfg_idx_i,
  input  wire logic [7:0]             cfg_wdata_i,
  tccc_in_if.sink                     in_i,
  tccc_out_if.source                  out_o
);

  cfg_t    cfg_q, cfg_d;
  cursor_t cur_q, cur_next;
  item_t   item_q;
  logic    in_vld_q, in_vld_d;
  logic    room;
  logic    fire;
  logic    accept;
  push_t   step_push;
  push_t   push;

  assign fire      = in_vld_q & room;
  assign in_i.ready = !in_vld_q || fire;
  assign accept    = in_i.valid & in_i.ready;
  assign in_vld_d  = accept | (in_vld_q & !fire);

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_COLUMNS:         cfg_d.columns         = cfg_wdata_i;
        REG_TEXT_ROWS:       cfg_d.text_rows       = cfg_wdata_i;
        REG_DISPLAY_PRESENT: cfg_d.display_present = cfg_wdata_i[0];
        REG_FIRST_GLYPH:     cfg_d.first_glyph     = cfg_wdata_i;
        REG_LAST_GLYPH:      cfg_d.last_glyph      = cfg_wdata_i;
        default:             cfg_d                 = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.columns         <= 8'd128;
      cfg_q.text_rows       <= 8'd48;
      cfg_q.display_present <= 1'b0;
      cfg_q.first_glyph     <= 8'd32;
      cfg_q.last_glyph      <= 8'd126;
      cur_q                 <= '0;
      in_vld_q              <= 1'b0;
    end else begin
      cfg_q    <= cfg_d;
      in_vld_q <= in_vld_d;
      if (fire) begin
        cur_q <= cur_next;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      item_q.mode      <= in_i.mode;
      item_q.char_code <= in_i.char_code;
      item_q.enable_on <= in_i.enable_on;
    end
  end

  tccc_step #(
    .CellWidth  (CellWidth),
    .CellHeight (CellHeight)
  ) u_step (
    .item_i (item_q),
    .cfg_i  (cfg_q),
    .cur_i  (cur_q),
    .cur_o  (cur_next),
    .push_o (step_push)
  );

  always_comb begin
    push       = step_push;
    push.valid = fire;
  end

  tccc_outbuf u_outbuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .room_o (room),
    .out_o  (out_o)
  );

endmodule

`default_nettype wire

FILE: test/text_console_cursor_control_test.sv
`timescale 1ns / 1ps
// Self-checking bench for text_console_cursor_control: directed table, then random text.
// Depends on tccc_pkg, tccc_in_if, tccc_out_if and the controller RTL.

module text_console_cursor_control_test;
  import tccc_pkg::*;

  localparam int unsigned CycleLimit = 400_000;
  localparam int unsigned TextItems  = 850;
  localparam int unsigned ChunkItems = 50;

  typedef struct {
    bit         is_cfg;
    reg_idx_e   idx;
    logic [7:0] wdata;
    item_t      it;
    int         fixed_n;
  } plan_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic cfg_we_i;
  logic [CfgIdxWidth-1:0] cfg_idx_i;
  logic [7:0] cfg_wdata_i;

  tccc_in_if  in_if ();
  tccc_out_if out_if ();

  text_console_cursor_control uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_i        (in_if.sink),
    .out_o       (out_if.source)
  );

  always #2 clk_i = ~clk_i;

  // Shadow of the controller: registers, cursor and console flag.
  cfg_t        shadow_cfg;
  int unsigned cur_col;
  int unsigned cur_line;
  bit          shadow_active;

  result_t     new_cmds[$];
  result_t     cmds_due[$];
  plan_row_t   plan[$];

  int unsigned send_gap_max = 12;
  int unsigned take_gap_max = 12;
  int unsigned faults = 0;
  int unsigned cycles = 0;

  initial begin
    rst_ni         <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= REG_COLUMNS;
    cfg_wdata_i    <= '0;
    in_if.valid    <= 1'b0;
    in_if.mode     <= 1'b0;
    in_if.char_code <= '0;
    in_if.enable_on <= 1'b0;
    out_if.ready   <= 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CycleLimit) begin
      $display("text_console_cursor_control_test: FAIL");
      $finish;
    end
  end

  function automatic result_t make_cmd(cmd_e c, logic [7:0] col, logic [7:0] row,
                                       logic [7:0] glyph);
    result_t r;
    r.command    = c;
    r.cell_col   = col;
    r.cell_row   = row;
    r.pixel_x    = 11'(col * CellWidthDefault);
    r.pixel_y    = 12'(row * CellHeightDefault);
    r.glyph_code = glyph;
    r.last       = 1'b0;
    return r;
  endfunction

  function automatic int unsigned at_least_one(logic [7:0] v);
    return (v == 0) ? 1 : v;
  endfunction

  function automatic void line_feed();
    if (cur_line + 1 >= at_least_one(shadow_cfg.text_rows)) begin
      cur_line = at_least_one(shadow_cfg.text_rows) - 1;
      new_cmds.push_back(make_cmd(CMD_SCROLL, 8'(0), 8'(cur_line), 8'(0)));
    end else begin
      cur_line = cur_line + 1;
    end
  endfunction

  function automatic void advance_col(int unsigned nxt);
    if (nxt >= at_least_one(shadow_cfg.columns)) begin
      cur_col = 0;
      line_feed();
    end else begin
      cur_col = nxt;
    end
  endfunction

  // Updates the shadow state for one item and leaves its commands in new_cmds.
  function automatic void predict_commands(item_t it);
    logic [7:0] glyph;
    new_cmds.delete();
    if (it.mode) begin
      shadow_active = it.enable_on && shadow_cfg.display_present;
      if (shadow_active) begin
        cur_col  = 0;
        cur_line = 0;
        new_cmds.push_back(make_cmd(CMD_CLEAR, 8'(0), 8'(0), 8'(0)));
      end
    end else if (shadow_active) begin
      case (it.char_code)
        CharCr: cur_col = 0;
        CharLf: begin
          cur_col = 0;
          line_feed();
        end
        CharBs: begin
          if (cur_col > 0) begin
            cur_col = cur_col - 1;
            new_cmds.push_back(make_cmd(CMD_DRAW, 8'(cur_col), 8'(cur_line), CharSpace));
          end
        end
        CharTab: advance_col((cur_col + TabStep) & ~(TabStep - 1));
        default: begin
          glyph = (it.char_code < shadow_cfg.first_glyph ||
                   it.char_code > shadow_cfg.last_glyph) ? CharSpace : it.char_code;
          new_cmds.push_back(make_cmd(CMD_DRAW, 8'(cur_col), 8'(cur_line), glyph));
          advance_col(cur_col + 1);
        end
      endcase
    end
    if (new_cmds.size() > 0) new_cmds[new_cmds.size()-1].last = 1'b1;
  endfunction

  // A negative fixed_n takes the prediction; otherwise 0 or a single clear is expected.
  task automatic send_item(item_t it, int fixed_n);
    int unsigned gap;
    result_t clear_cmd;
    gap = (send_gap_max == 0) ? 0 : $urandom_range(0, send_gap_max);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid     <= 1'b1;
    in_if.mode      <= it.mode;
    in_if.char_code <= it.char_code;
    in_if.enable_on <= it.enable_on;
    do @(posedge clk_i); while (!in_if.ready);
    predict_commands(it);
    if (fixed_n < 0) begin
      foreach (new_cmds[k]) cmds_due.push_back(new_cmds[k]);
    end else if (fixed_n == 1) begin
      clear_cmd = make_cmd(CMD_CLEAR, 8'(0), 8'(0), 8'(0));
      clear_cmd.last = 1'b1;
      cmds_due.push_back(clear_cmd);
    end
  endtask

  task automatic cfg_write(reg_idx_e idx, logic [7:0] v);
    in_if.valid <= 1'b0;
    while (cmds_due.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      REG_COLUMNS:         shadow_cfg.columns         = v;
      REG_TEXT_ROWS:       shadow_cfg.text_rows       = v;
      REG_DISPLAY_PRESENT: shadow_cfg.display_present = v[0];
      REG_FIRST_GLYPH:     shadow_cfg.first_glyph     = v;
      REG_LAST_GLYPH:      shadow_cfg.last_glyph      = v;
      default: ;
    endcase
  endtask

  function automatic void plan_cfg(reg_idx_e idx, logic [7:0] v);
    plan_row_t row;
    row.is_cfg  = 1'b1;
    row.idx     = idx;
    row.wdata   = v;
    row.it      = '0;
    row.fixed_n = -1;
    plan.push_back(row);
  endfunction

  function automatic void plan_item(logic mode, logic [7:0] ch, logic on, int fixed_n);
    plan_row_t row;
    row.is_cfg       = 1'b0;
    row.idx          = REG_COLUMNS;
    row.wdata        = '0;
    row.it.mode      = mode;
    row.it.char_code = ch;
    row.it.enable_on = on;
    row.fixed_n      = fixed_n;
    plan.push_back(row);
  endfunction

  function automatic logic [7:0] pick_char();
    case ($urandom_range(0, 11))
      0: return CharCr;
      1: return CharLf;
      2: return CharBs;
      3: return CharTab;
      4: return CharSpace;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic int unsigned pick_gap_max();
    case ($urandom_range(0, 2))
      0: return 0;
      1: return 3;
      default: return 12;
    endcase
  endfunction

  initial begin : take_results
    result_t want;
    result_t got;
    int unsigned stall;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      stall = (take_gap_max == 0) ? 0 : $urandom_range(0, take_gap_max);
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
      do @(posedge clk_i); while (out_if.valid !== 1'b1);
      got.command    = cmd_e'(out_if.command);
      got.cell_col   = out_if.cell_col;
      got.cell_row   = out_if.cell_row;
      got.pixel_x    = out_if.pixel_x;
      got.pixel_y    = out_if.pixel_y;
      got.glyph_code = out_if.glyph_code;
      got.last       = out_if.last;
      if (cmds_due.size() == 0) begin
        faults++;
        if (faults <= 10)
          $display("%0t: unexpected command %0d col=%0d row=%0d", $realtime,
                   got.command, got.cell_col, got.cell_row);
      end else begin
        want = cmds_due.pop_front();
        if (got.command !== want.command || got.cell_col !== want.cell_col ||
            got.cell_row !== want.cell_row || got.pixel_x !== want.pixel_x ||
            got.pixel_y !== want.pixel_y || got.glyph_code !== want.glyph_code ||
            got.last !== want.last) begin
          faults++;
          if (faults <= 10)
            $display({"%0t: mismatch want cmd=%0d col=%0d row=%0d px=%0d py=%0d g=%02h",
                      " last=%0d / got cmd=%0d col=%0d row=%0d px=%0d py=%0d g=%02h last=%0d"},
                     $realtime, want.command, want.cell_col, want.cell_row, want.pixel_x,
                     want.pixel_y, want.glyph_code, want.last, got.command, got.cell_col,
                     got.cell_row, got.pixel_x, got.pixel_y, got.glyph_code, got.last);
        end
      end
    end
  end

  initial begin : drive_items
    item_t it;
    int unsigned done_items;
    int unsigned chunk_items;
    shadow_cfg.columns         = 8'd128;
    shadow_cfg.text_rows       = 8'd48;
    shadow_cfg.display_present = 1'b0;
    shadow_cfg.first_glyph     = 8'd32;
    shadow_cfg.last_glyph      = 8'd126;
    cur_col       = 0;
    cur_line      = 0;
    shadow_active = 1'b0;

    // Console off after reset; enabling needs a display.
    plan_item(1'b0, 8'h41, 1'b0, 0);
    plan_item(1'b1, 8'h00, 1'b1, 0);
    plan_cfg(REG_DISPLAY_PRESENT, 8'd1);
    plan_item(1'b1, 8'hFF, 1'b1, 1);
    plan_item(1'b0, CharBs, 1'b0, 0);
    plan_item(1'b0, 8'h41, 1'b1, -1);
    plan_item(1'b0, 8'h00, 1'b0, -1);
    plan_item(1'b0, 8'hFF, 1'b0, -1);
    plan_item(1'b0, 8'h20, 1'b0, -1);
    plan_item(1'b0, 8'h7E, 1'b0, -1);
    plan_item(1'b0, CharBs, 1'b0, -1);
    plan_item(1'b0, CharTab, 1'b0, -1);
    plan_item(1'b0, CharCr, 1'b0, -1);
    plan_item(1'b0, CharLf, 1'b0, -1);
    // Narrow screen: wrap and scroll on the last row, tab past the line end.
    plan_cfg(REG_COLUMNS, 8'd3);
    plan_cfg(REG_TEXT_ROWS, 8'd2);
    plan_item(1'b0, 8'h78, 1'b0, -1);
    plan_item(1'b0, 8'h79, 1'b0, -1);
    plan_item(1'b0, 8'h7A, 1'b0, -1);
    plan_item(1'b0, CharTab, 1'b0, -1);
    // Zero geometry counts as one cell.
    plan_cfg(REG_COLUMNS, 8'd0);
    plan_cfg(REG_TEXT_ROWS, 8'd0);
    plan_item(1'b0, 8'h71, 1'b0, -1);
    plan_item(1'b0, CharLf, 1'b0, -1);
    plan_cfg(REG_COLUMNS, 8'd255);
    plan_cfg(REG_TEXT_ROWS, 8'd255);
    plan_cfg(REG_FIRST_GLYPH, 8'd0);
    plan_cfg(REG_LAST_GLYPH, 8'd255);
    plan_item(1'b1, 8'h55, 1'b1, 1);
    plan_item(1'b0, 8'h00, 1'b1, -1);
    plan_item(1'b0, 8'hFF, 1'b1, -1);
    // Empty font range.
    plan_cfg(REG_FIRST_GLYPH, 8'd255);
    plan_cfg(REG_LAST_GLYPH, 8'd0);
    plan_item(1'b0, 8'h41, 1'b0, -1);
    plan_item(1'b1, 8'hAA, 1'b0, 0);
    plan_item(1'b0, 8'h42, 1'b1, 0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].is_cfg) cfg_write(plan[i].idx, plan[i].wdata);
      else send_item(plan[i].it, plan[i].fixed_n);
    end

    done_items = 0;
    while (done_items < TextItems) begin
      case ($urandom_range(0, 7))
        0: cfg_write(REG_COLUMNS, 8'd0);
        1: cfg_write(REG_COLUMNS, 8'd255);
        2: cfg_write(REG_COLUMNS, 8'($urandom_range(1, 255)));
        default: cfg_write(REG_COLUMNS, 8'($urandom_range(1, 12)));
      endcase
      case ($urandom_range(0, 7))
        0: cfg_write(REG_TEXT_ROWS, 8'd0);
        1: cfg_write(REG_TEXT_ROWS, 8'd255);
        2: cfg_write(REG_TEXT_ROWS, 8'($urandom_range(1, 255)));
        default: cfg_write(REG_TEXT_ROWS, 8'($urandom_range(1, 6)));
      endcase
      cfg_write(REG_DISPLAY_PRESENT, 8'($urandom_range(0, 7) != 0));
      if ($urandom_range(0, 3) == 0) cfg_write(REG_FIRST_GLYPH, 8'($urandom_range(0, 255)));
      else cfg_write(REG_FIRST_GLYPH, 8'($urandom_range(0, 64)));
      if ($urandom_range(0, 4) == 0) cfg_write(REG_LAST_GLYPH, 8'($urandom_range(0, 255)));
      else cfg_write(REG_LAST_GLYPH, 8'($urandom_range(shadow_cfg.first_glyph, 255)));
      send_gap_max = pick_gap_max();
      take_gap_max = pick_gap_max();

      // Keeping the cursor across a geometry change exercises an out-of-range cursor.
      if (!shadow_active || $urandom_range(0, 2) == 0) begin
        it.mode      = 1'b1;
        it.char_code = 8'($urandom_range(0, 255));
        it.enable_on = 1'b1;
        send_item(it, -1);
        done_items++;
      end

      chunk_items = 0;
      while (chunk_items < ChunkItems && done_items < TextItems) begin
        it.mode      = shadow_active ? ($urandom_range(0, 29) == 0)
                                     : ($urandom_range(0, 2) == 0);
        it.char_code = pick_char();
        it.enable_on = ($urandom_range(0, 5) != 0);
        send_item(it, -1);
        chunk_items++;
        done_items++;
      end
    end

    in_if.valid <= 1'b0;
    while (cmds_due.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    if (faults == 0) begin
      $display("text_console_cursor_control_test: PASS");
    end else begin
      $display("text_console_cursor_control_test: FAIL");
    end
    $finish;
  end

endmodule
